// ----- rtl/scbl_pkg.sv -----
// ============================================================================
// scbl_pkg - shared types and constants of the six-channel biquad low-pass
// Sample, coefficient and history formats, coefficient register codes and
// the request structs of the sample and result channels.
// ============================================================================
`default_nettype none

package scbl_pkg;

    // filter geometry
    localparam int CHANNELS        = 6;
    localparam int SAMPLE_BITS     = 16;
    localparam int COEFF_FRAC_BITS = 22;
    localparam int COEFF_BITS      = 24;
    localparam int EXTRA_FRAC      = 8;
    localparam int HIST_BITS       = SAMPLE_BITS + EXTRA_FRAC;

    // accumulator: wide enough for five terms, capped at 64 bits (wraps there)
    localparam int ACC_RAW   = SAMPLE_BITS + COEFF_BITS + EXTRA_FRAC + 3;
    localparam int ACC_NEED  = COEFF_FRAC_BITS + HIST_BITS + 1;
    localparam int ACC_WIDE  = (ACC_RAW > ACC_NEED) ? ACC_RAW : ACC_NEED;
    localparam int ACC_BITS  = (ACC_WIDE > 64) ? 64 : ACC_WIDE;
    localparam int QUOT_BITS = ACC_BITS - COEFF_FRAC_BITS;
    localparam int SAT_BITS  = ((QUOT_BITS > HIST_BITS) ? QUOT_BITS : HIST_BITS) + 1;

    // coefficient registers
    localparam int NUM_COEFFS     = 5;
    localparam int CFG_INDEX_BITS = 3;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        COEFF_B0 = 3'd0,
        COEFF_B1 = 3'd1,
        COEFF_B2 = 3'd2,
        COEFF_A1 = 3'd3,
        COEFF_A2 = 3'd4
    } coeff_idx_t;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [COEFF_BITS-1:0]  coeff_t;
    typedef logic signed [HIST_BITS-1:0]   hist_t;

    localparam coeff_t B0_RESET = 24'sd22230;
    localparam coeff_t B1_RESET = 24'sd44040;
    localparam coeff_t B2_RESET = 24'sd22230;
    localparam coeff_t A1_RESET = -24'sd7797728;
    localparam coeff_t A2_RESET = 24'sd3691826;

    typedef struct packed {
        sample_t accel_x;
        sample_t accel_y;
        sample_t accel_z;
        sample_t rate_x;
        sample_t rate_y;
        sample_t rate_z;
    } imu_in_t;

    typedef struct packed {
        sample_t filt_accel_x;
        sample_t filt_accel_y;
        sample_t filt_accel_z;
        sample_t filt_rate_x;
        sample_t filt_rate_y;
        sample_t filt_rate_z;
    } imu_out_t;

endpackage

`default_nettype wire

// ----- rtl/six_channel_biquad_lowpass.sv -----
// ============================================================================
// six_channel_biquad_lowpass - six-channel second-order low-pass filter
// Direct-form-I biquad per IMU channel with shared Q2.22 coefficients.
// ============================================================================
//
// One request on the s_ channel carries a full IMU sample set (three
// acceleration and three angular-rate readings); each channel runs through
// its own direct-form-I biquad, y = b0*x0 + b1*x1 + b2*x2 - a1*y1 - a2*y2,
// with the five shared signed Q2.22 coefficients from the cfg_ port, and one
// result request with the six filtered samples, saturated to 16 bits, comes
// out on the m_ channel. The block takes one request every clock cycle
// while the result side is not stalled; an accepted request waits in the
// input register and its result in the result register. That rate is set
// by the per-channel feedback loop: the five products, their sum, rounding
// and saturation of the new output all settle combinationally between the
// input and result registers, so the next sample sees it at once. Output
// history is kept in Q16.8 and saturates instead of wrapping. After reset
// the history is zero and the coefficients hold a default low-pass design.
// The user must write coefficients only while the block is idle; the block
// does not enforce it. cfg_ready is always high; writes past a2 are dropped.
//
`default_nettype none

module six_channel_biquad_lowpass (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // sample requests
    input  wire logic                                 s_valid,
    output      logic                                 s_ready,
    input  wire scbl_pkg::imu_in_t                    s_data,
    // result requests
    output      logic                                 m_valid,
    input  wire logic                                 m_ready,
    output      scbl_pkg::imu_out_t                   m_data,
    // coefficient writes
    input  wire logic                                 cfg_valid,
    output      logic                                 cfg_ready,
    input  wire logic [scbl_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire scbl_pkg::coeff_t                     cfg_data
);

    localparam int CH = scbl_pkg::CHANNELS;

    // rounding constants: half an lsb of the stored output and of the result
    localparam logic signed [scbl_pkg::ACC_BITS-1:0] ROUND_ACC =
        scbl_pkg::ACC_BITS'(1) <<< (scbl_pkg::COEFF_FRAC_BITS - 1);
    localparam logic signed [scbl_pkg::HIST_BITS:0] ROUND_OUT =
        (scbl_pkg::HIST_BITS + 1)'(1) <<< (scbl_pkg::EXTRA_FRAC - 1);

    // saturation bounds
    localparam logic signed [scbl_pkg::SAT_BITS-1:0] HIST_MAX =
        scbl_pkg::SAT_BITS'({1'b0, {(scbl_pkg::HIST_BITS-1){1'b1}}});
    localparam logic signed [scbl_pkg::SAT_BITS-1:0] HIST_MIN = ~HIST_MAX;
    localparam logic signed [scbl_pkg::SAMPLE_BITS:0] SAMPLE_MAX =
        (scbl_pkg::SAMPLE_BITS + 1)'({1'b0, {(scbl_pkg::SAMPLE_BITS-1){1'b1}}});
    localparam logic signed [scbl_pkg::SAMPLE_BITS:0] SAMPLE_MIN = ~SAMPLE_MAX;

    // new stored output of one channel, Q16.8, rounded half up and saturated
    function automatic scbl_pkg::hist_t biquad_out(
        input scbl_pkg::sample_t x0,
        input scbl_pkg::sample_t x1,
        input scbl_pkg::sample_t x2,
        input scbl_pkg::hist_t   y1,
        input scbl_pkg::hist_t   y2,
        input scbl_pkg::coeff_t  b0,
        input scbl_pkg::coeff_t  b1,
        input scbl_pkg::coeff_t  b2,
        input scbl_pkg::coeff_t  a1,
        input scbl_pkg::coeff_t  a2
    );
        logic signed [scbl_pkg::SAMPLE_BITS+scbl_pkg::COEFF_BITS-1:0] p0, p1, p2;
        logic signed [scbl_pkg::HIST_BITS+scbl_pkg::COEFF_BITS-1:0]   p3, p4;
        logic signed [scbl_pkg::ACC_BITS-1:0]                         ff, fb, acc;
        logic signed [scbl_pkg::QUOT_BITS-1:0]                        quot;
        logic signed [scbl_pkg::SAT_BITS-1:0]                         wide;
        p0   = b0 * x0;
        p1   = b1 * x1;
        p2   = b2 * x2;
        p3   = a1 * y1;
        p4   = a2 * y2;
        ff   = scbl_pkg::ACC_BITS'(p0) + scbl_pkg::ACC_BITS'(p1)
             + scbl_pkg::ACC_BITS'(p2);
        fb   = scbl_pkg::ACC_BITS'(p3) + scbl_pkg::ACC_BITS'(p4);
        acc  = (ff <<< scbl_pkg::EXTRA_FRAC) - fb + ROUND_ACC;
        // floor division by 2^frac: the upper bits taken as signed
        quot = acc[scbl_pkg::ACC_BITS-1:scbl_pkg::COEFF_FRAC_BITS];
        wide = scbl_pkg::SAT_BITS'(quot);
        if (wide > HIST_MAX) begin
            wide = HIST_MAX;
        end else if (wide < HIST_MIN) begin
            wide = HIST_MIN;
        end
        return wide[scbl_pkg::HIST_BITS-1:0];
    endfunction

    // result sample from Q16.8, rounded half up and saturated
    function automatic scbl_pkg::sample_t to_sample(input scbl_pkg::hist_t y);
        logic signed [scbl_pkg::HIST_BITS:0]   sum;
        logic signed [scbl_pkg::SAMPLE_BITS:0] q;
        sum = (scbl_pkg::HIST_BITS + 1)'(y) + ROUND_OUT;
        q   = sum[scbl_pkg::HIST_BITS:scbl_pkg::EXTRA_FRAC];
        if (q > SAMPLE_MAX) begin
            q = SAMPLE_MAX;
        end else if (q < SAMPLE_MIN) begin
            q = SAMPLE_MIN;
        end
        return q[scbl_pkg::SAMPLE_BITS-1:0];
    endfunction

    // coefficient registers
    scbl_pkg::coeff_t b0_reg, b1_reg, b2_reg, a1_reg, a2_reg;

    // input register
    logic               in_valid_reg;
    scbl_pkg::imu_in_t  in_data_reg;

    // per-channel history: inputs one and two back, outputs one and two back
    scbl_pkg::sample_t  x1_reg [CH];
    scbl_pkg::sample_t  x2_reg [CH];
    scbl_pkg::hist_t    y1_reg [CH];
    scbl_pkg::hist_t    y2_reg [CH];

    // result register
    logic               m_valid_reg;
    scbl_pkg::imu_out_t m_data_reg;

    // datapath
    scbl_pkg::sample_t  x0      [CH];
    scbl_pkg::hist_t    y_next  [CH];
    scbl_pkg::sample_t  r_next  [CH];
    scbl_pkg::imu_out_t m_data_next;
    logic               advance;

    // the held sample set moves on whenever the result register is free
    assign advance   = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign cfg_ready = 1'b1;

    // coefficient writes, unknown indexes dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b0_reg <= scbl_pkg::B0_RESET;
            b1_reg <= scbl_pkg::B1_RESET;
            b2_reg <= scbl_pkg::B2_RESET;
            a1_reg <= scbl_pkg::A1_RESET;
            a2_reg <= scbl_pkg::A2_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                scbl_pkg::COEFF_B0: b0_reg <= cfg_data;
                scbl_pkg::COEFF_B1: b1_reg <= cfg_data;
                scbl_pkg::COEFF_B2: b2_reg <= cfg_data;
                scbl_pkg::COEFF_A1: a1_reg <= cfg_data;
                scbl_pkg::COEFF_A2: a2_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // channel order follows the request struct
    always_comb begin
        x0[0] = in_data_reg.accel_x;
        x0[1] = in_data_reg.accel_y;
        x0[2] = in_data_reg.accel_z;
        x0[3] = in_data_reg.rate_x;
        x0[4] = in_data_reg.rate_y;
        x0[5] = in_data_reg.rate_z;
    end

    // one biquad per channel, all in parallel
    always_comb begin
        for (int ch = 0; ch < CH; ch++) begin
            y_next[ch] = biquad_out(x0[ch], x1_reg[ch], x2_reg[ch],
                                    y1_reg[ch], y2_reg[ch],
                                    b0_reg, b1_reg, b2_reg, a1_reg, a2_reg);
            r_next[ch] = to_sample(y_next[ch]);
        end
    end

    always_comb begin
        m_data_next.filt_accel_x = r_next[0];
        m_data_next.filt_accel_y = r_next[1];
        m_data_next.filt_accel_z = r_next[2];
        m_data_next.filt_rate_x  = r_next[3];
        m_data_next.filt_rate_y  = r_next[4];
        m_data_next.filt_rate_z  = r_next[5];
    end

    // handshake control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            m_data_reg <= m_data_next;
        end
    end

    // filter history shifts once per sample set that leaves the input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int ch = 0; ch < CH; ch++) begin
                x1_reg[ch] <= '0;
                x2_reg[ch] <= '0;
                y1_reg[ch] <= '0;
                y2_reg[ch] <= '0;
            end
        end else if (advance) begin
            for (int ch = 0; ch < CH; ch++) begin
                x2_reg[ch] <= x1_reg[ch];
                x1_reg[ch] <= x0[ch];
                y2_reg[ch] <= y1_reg[ch];
                y1_reg[ch] <= y_next[ch];
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/scbl_checker.sv -----
// ============================================================================
// scbl_checker - port-level checks of the six-channel biquad low-pass
// Watches the sample, result and coefficient ports over time.
// ============================================================================
`default_nettype none

module scbl_checker (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_valid,
    input wire logic s_ready,
    input wire logic m_valid,
    input wire logic m_ready,
    input wire scbl_pkg::imu_out_t m_data,
    input wire logic cfg_ready
);

    // an accepted sample set is followed by a valid result
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |-> ##2 m_valid)
        else $error("accepted request produced no result");

    // the sample side only blocks behind a stalled result
    a_block_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("sample side blocked without a stalled result");

    // a stalled result holds
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed or dropped");

    // reset empties both registers and opens every port
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready && cfg_ready)
        else $error("block not empty after reset");

endmodule

bind six_channel_biquad_lowpass scbl_checker u_scbl_checker (.*);

`default_nettype wire

// ----- tb/scbl_checker.sv -----
// ============================================================================
// scbl_scoreboard - result predictor and comparator for the biquad low-pass
// Follows coefficient writes and sample requests, runs its own six-lane
// direct-form-I filter and compares every result request field by field.
// ============================================================================

module scbl_scoreboard (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  scbl_pkg::imu_in_t                   s_data,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  scbl_pkg::imu_out_t                  m_data,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [scbl_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  scbl_pkg::coeff_t                    cfg_data,
    output int                                  fail_count,
    output int                                  results_due
);

    typedef logic [scbl_pkg::CHANNELS-1:0][scbl_pkg::SAMPLE_BITS-1:0] lanes_t;

    scbl_pkg::coeff_t   coeffs [scbl_pkg::NUM_COEFFS];
    scbl_pkg::sample_t  x_hist [scbl_pkg::CHANNELS][2];
    scbl_pkg::hist_t    y_hist [scbl_pkg::CHANNELS][2];
    scbl_pkg::imu_out_t filtered_q [$];
    scbl_pkg::imu_out_t predicted;
    int                 mismatches = 0;
    int                 results_seen = 0;
    lanes_t             got_lanes;
    lanes_t             want_lanes;

    // lane 0 is the least significant field of the struct
    function automatic string lane_label(int ln);
        case (ln)
            0: return "rate_z";
            1: return "rate_y";
            2: return "rate_x";
            3: return "accel_z";
            4: return "accel_y";
            default: return "accel_x";
        endcase
    endfunction

    function automatic longint clamp(longint v, int w);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    // one step of all six filters, history updated in place
    function automatic scbl_pkg::imu_out_t run_biquads(scbl_pkg::imu_in_t smp);
        lanes_t xin;
        lanes_t yout;
        longint kb0, kb1, kb2, ka1, ka2;
        longint x0, x1, x2, y1, y2, ff, fb, acc, y, r;
        longint half_acc, half_out;
        half_acc = longint'(1) <<< (scbl_pkg::COEFF_FRAC_BITS - 1);
        half_out = longint'(1) <<< (scbl_pkg::EXTRA_FRAC - 1);
        xin = smp;
        kb0 = coeffs[scbl_pkg::COEFF_B0];
        kb1 = coeffs[scbl_pkg::COEFF_B1];
        kb2 = coeffs[scbl_pkg::COEFF_B2];
        ka1 = coeffs[scbl_pkg::COEFF_A1];
        ka2 = coeffs[scbl_pkg::COEFF_A2];
        for (int ln = 0; ln < scbl_pkg::CHANNELS; ln++) begin
            x0 = scbl_pkg::sample_t'(xin[ln]);
            x1 = x_hist[ln][0];
            x2 = x_hist[ln][1];
            y1 = y_hist[ln][0];
            y2 = y_hist[ln][1];
            ff = kb0 * x0 + kb1 * x1 + kb2 * x2;
            fb = ka1 * y1 + ka2 * y2;
            acc = (ff <<< scbl_pkg::EXTRA_FRAC) - fb + half_acc;
            y = clamp(acc >>> scbl_pkg::COEFF_FRAC_BITS, scbl_pkg::HIST_BITS);
            r = clamp((y + half_out) >>> scbl_pkg::EXTRA_FRAC, scbl_pkg::SAMPLE_BITS);
            x_hist[ln][1] = x_hist[ln][0];
            x_hist[ln][0] = scbl_pkg::sample_t'(x0);
            y_hist[ln][1] = y_hist[ln][0];
            y_hist[ln][0] = scbl_pkg::hist_t'(y);
            yout[ln] = r[scbl_pkg::SAMPLE_BITS-1:0];
        end
        return yout;
    endfunction

    task automatic report_mismatch(string msg);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            coeffs[scbl_pkg::COEFF_B0] = scbl_pkg::B0_RESET;
            coeffs[scbl_pkg::COEFF_B1] = scbl_pkg::B1_RESET;
            coeffs[scbl_pkg::COEFF_B2] = scbl_pkg::B2_RESET;
            coeffs[scbl_pkg::COEFF_A1] = scbl_pkg::A1_RESET;
            coeffs[scbl_pkg::COEFF_A2] = scbl_pkg::A2_RESET;
            for (int ln = 0; ln < scbl_pkg::CHANNELS; ln++) begin
                x_hist[ln] = '{default: '0};
                y_hist[ln] = '{default: '0};
            end
            filtered_q.delete();
        end else begin
            if (cfg_valid && cfg_ready && cfg_index < scbl_pkg::NUM_COEFFS)
                coeffs[cfg_index] = cfg_data;
            if (s_valid && s_ready) begin
                predicted  = run_biquads(s_data);
                filtered_q = {filtered_q, predicted};
            end
            if (m_valid && m_ready) begin
                results_seen++;
                if (filtered_q.size() == 0) begin
                    report_mismatch("result request with nothing outstanding");
                end else begin
                    want_lanes = filtered_q.pop_front();
                    got_lanes  = m_data;
                    for (int ln = 0; ln < scbl_pkg::CHANNELS; ln++)
                        if (got_lanes[ln] !== want_lanes[ln])
                            report_mismatch($sformatf("result %0d filt_%s got %0d, expected %0d",
                                results_seen, lane_label(ln),
                                scbl_pkg::sample_t'(got_lanes[ln]),
                                scbl_pkg::sample_t'(want_lanes[ln])));
                end
            end
        end
        fail_count  <= mismatches;
        results_due <= filtered_q.size();
    end

endmodule

// ----- tb/tb_six_channel_biquad_lowpass.sv -----
// ============================================================================
// tb_six_channel_biquad_lowpass - testbench of the six-lane biquad low-pass
// Directed step, extreme and alternating inputs under the reset coefficients,
// then eight random phases, each with its own coefficient set and idling mode;
// a side checker predicts every result request and compares it.
// ============================================================================

module tb_six_channel_biquad_lowpass;

    typedef logic [scbl_pkg::CHANNELS-1:0][scbl_pkg::SAMPLE_BITS-1:0] lanes_t;

    localparam int      ITEMS_PER_PHASE = 160;
    localparam int      NUM_PHASES      = 8;
    localparam int      QUIET_LIMIT     = 4000;
    localparam scbl_pkg::sample_t SAMPLE_MAX  = 16'sh7fff;
    localparam scbl_pkg::sample_t SAMPLE_MIN  = 16'sh8000;
    localparam scbl_pkg::coeff_t  COEFF_MAX   = 24'sh7fffff;
    localparam scbl_pkg::coeff_t  COEFF_MIN   = 24'sh800000;
    localparam scbl_pkg::coeff_t  COEFF_UNITY =
        scbl_pkg::coeff_t'(1 << scbl_pkg::COEFF_FRAC_BITS);

    // clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    // every block input starts at a known value
    logic                                s_valid   = 1'b0;
    logic                                s_ready;
    scbl_pkg::imu_in_t                   s_data    = '0;
    logic                                m_valid;
    logic                                m_ready   = 1'b0;
    scbl_pkg::imu_out_t                  m_data;
    logic                                cfg_valid = 1'b0;
    logic                                cfg_ready;
    logic [scbl_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
    scbl_pkg::coeff_t                    cfg_data  = '0;

    int fail_count;
    int results_due;

    // idling percentages, changed per phase
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // run statistics for the summary
    int items_sent   = 0;
    int reg_writes   = 0;
    int stray_writes = 0;
    int quiet_cycles = 0;

    always #10 aclk = ~aclk;

    six_channel_biquad_lowpass u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    scbl_scoreboard u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .results_due (results_due)
    );

    // result side back-pressure, redrawn every cycle
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog: too long without any request moving on any channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no request moved for %0d cycles", QUIET_LIMIT);
            $display("six_channel_biquad_lowpass verification failed");
            $finish;
        end
    end

    // one sample request; valid stays up afterwards so back-to-back requests
    // need no extra edge, the idle loop or a drain lowers it
    task automatic send_sample(scbl_pkg::imu_in_t smp);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= smp;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    // lower valid and hold off until every outstanding result has come back
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (results_due != 0);
    endtask

    // one coefficient write, valid left high for the next one in the batch
    task automatic write_reg(logic [scbl_pkg::CFG_INDEX_BITS-1:0] idx,
                             scbl_pkg::coeff_t val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        reg_writes++;
    endtask

    // full coefficient set, preceded by a write past the last register that
    // must leave every coefficient untouched
    task automatic load_coeffs(scbl_pkg::coeff_t b0, scbl_pkg::coeff_t b1,
                               scbl_pkg::coeff_t b2, scbl_pkg::coeff_t a1,
                               scbl_pkg::coeff_t a2);
        write_reg(scbl_pkg::CFG_INDEX_BITS'(scbl_pkg::NUM_COEFFS + $urandom_range(2)),
                  scbl_pkg::coeff_t'($urandom));
        stray_writes++;
        write_reg(scbl_pkg::COEFF_B0, b0);
        write_reg(scbl_pkg::COEFF_B1, b1);
        write_reg(scbl_pkg::COEFF_B2, b2);
        write_reg(scbl_pkg::COEFF_A1, a1);
        write_reg(scbl_pkg::COEFF_A2, a2);
        cfg_valid <= 1'b0;
    endtask

    // next sample of one lane: mostly random, some slow drift so the filter
    // settles, some rail values and some near zero
    function automatic scbl_pkg::sample_t next_level(scbl_pkg::sample_t prev);
        int pick;
        pick = $urandom_range(9);
        if (pick <= 3)
            return scbl_pkg::sample_t'($urandom);
        else if (pick <= 6)
            return scbl_pkg::sample_t'(int'(prev) + int'($urandom_range(512)) - 256);
        else if (pick == 7)
            return $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
        else
            return scbl_pkg::sample_t'(int'($urandom_range(64)) - 32);
    endfunction

    initial begin
        lanes_t level;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed part under the reset coefficients: silence, a positive
        // step to the rail (the default design overshoots, so the output
        // clips), a negative step, a full-swing tone at half the sample
        // rate and two mixed sets with rails, +-1 and bit patterns
        for (int k = 0; k < 20; k++) begin
            if (k < 2)
                level = '0;
            else if (k < 8)
                level = {scbl_pkg::CHANNELS{SAMPLE_MAX}};
            else if (k < 14)
                level = {scbl_pkg::CHANNELS{SAMPLE_MIN}};
            else if (k < 18)
                level = (k % 2) ? {scbl_pkg::CHANNELS{SAMPLE_MAX}}
                                : {scbl_pkg::CHANNELS{SAMPLE_MIN}};
            else if (k == 18)
                level = {SAMPLE_MAX, SAMPLE_MIN, 16'sd1, -16'sd1, 16'sh5555, 16'shaaaa};
            else
                level = {16'shaaaa, 16'sh5555, -16'sd1, 16'sd1, SAMPLE_MIN, SAMPLE_MAX};
            send_sample(scbl_pkg::imu_in_t'(level));
        end
        wait_drained();

        // random phases: idling mode cycles through none, sender, receiver
        // and both, so each mode is met by two of the coefficient sets
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
                default: begin send_idle_pct = 15; recv_stall_pct = 15; end
            endcase

            // block is idle here, the previous phase has drained
            case (phase)
                // straight pass-through, output equals input
                0: load_coeffs(COEFF_UNITY, '0, '0, '0, '0);
                // every coefficient at the positive rail, history clips
                2: load_coeffs(COEFF_MAX, COEFF_MAX, COEFF_MAX, COEFF_MAX, COEFF_MAX);
                // every coefficient at the negative rail
                3: load_coeffs(COEFF_MIN, COEFF_MIN, COEFF_MIN, COEFF_MIN, COEFF_MIN);
                // poles well outside the unit circle, output history saturates
                4: load_coeffs(COEFF_MAX, '0, '0, COEFF_MIN, COEFF_MAX);
                // back to the default low-pass design
                6: load_coeffs(scbl_pkg::B0_RESET, scbl_pkg::B1_RESET, scbl_pkg::B2_RESET,
                               scbl_pkg::A1_RESET, scbl_pkg::A2_RESET);
                // random feedforward only, no feedback
                7: load_coeffs(scbl_pkg::coeff_t'($urandom), scbl_pkg::coeff_t'($urandom),
                               scbl_pkg::coeff_t'($urandom), '0, '0);
                // anything goes
                default: load_coeffs(scbl_pkg::coeff_t'($urandom),
                                     scbl_pkg::coeff_t'($urandom),
                                     scbl_pkg::coeff_t'($urandom),
                                     scbl_pkg::coeff_t'($urandom),
                                     scbl_pkg::coeff_t'($urandom));
            endcase

            level = '0;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // now and then the sender holds back until everything is out
                if (n == ITEMS_PER_PHASE / 2 || $urandom_range(39) == 0)
                    wait_drained();
                for (int ln = 0; ln < scbl_pkg::CHANNELS; ln++)
                    level[ln] = next_level(scbl_pkg::sample_t'(level[ln]));
                send_sample(scbl_pkg::imu_in_t'(level));
            end
            wait_drained();
        end

        // spare edges after the input and result registers catch any stray result
        repeat (8) @(posedge aclk);

        $display("summary: %0d sample requests, %0d directed, over %0d coefficient sets",
                 items_sent, 20, NUM_PHASES + 1);
        $display("summary: %0d register writes (%0d to unused indexes), idling off/84/84/15",
                 reg_writes, stray_writes);
        if (fail_count == 0)
            $display("six_channel_biquad_lowpass verification clean");
        else
            $display("six_channel_biquad_lowpass verification failed");
        $finish;
    end

endmodule
